### sv/ookpwd_pkg.sv
//------------------------------------------------------------------------------
// ookpwd_pkg
// Shared types, constants and timing tables of the OOK pulse width decoder.
//------------------------------------------------------------------------------
`default_nettype none

package ookpwd_pkg;

   // Field widths
   localparam int DUR_W     = 16;
   localparam int UNIT_W    = 13;
   localparam int WIN_W     = 14;
   localparam int CNT_W     = 8;
   localparam int PROT_W    = 2;
   localparam int TOL_W     = 7;
   localparam int CODE_W    = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 7;

   // Frame limits
   localparam logic [CNT_W-1:0] MAX_CHANGES  = 8'd67;
   localparam logic [CNT_W-1:0] STORED_MIN   = 8'd6;
   localparam int               CODE_BITS_DEF = 32;

   // Constant divider: quotient = (num * recip) >> DIV_SHIFT, one correction step
   localparam int DIV_SHIFT = 20;
   localparam int NUM_W     = 20;
   localparam int RECIP_W   = 17;
   localparam int DIVR_W    = 7;
   localparam int PROD_W    = NUM_W + RECIP_W;
   localparam int QC_W      = 24;
   localparam int CTR_W     = 17;
   localparam int MULT_W    = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROTOCOL  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 1'b1;

   // Protocol codes
   localparam logic [PROT_W-1:0] PROTO_ONE   = 2'd0;
   localparam logic [PROT_W-1:0] PROTO_TWO   = 2'd1;
   localparam logic [PROT_W-1:0] PROTO_THREE = 2'd2;
   localparam logic [PROT_W-1:0] PROTO_RSVD  = 2'd3;

   // Divisor selects: the three sync factors share codes with the protocols
   localparam logic [PROT_W-1:0] DIV_PERCENT = 2'd3;

   localparam logic [TOL_W-1:0] TOL_RESET = 7'd60;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;    // take the accepted item
      logic div_mul;    // first half of a constant division
      logic div_win;    // divide the tolerance product instead of the duration
      logic unit_fix;   // unit from quotient, open the frame
      logic tol_mul;    // unit times tolerance percent
      logic win_fix;    // window from quotient
      logic step;       // pulse count and pair phase
      logic centre;     // window centres for both bit patterns
      logic classify;   // pair compare and code shift
      logic finish;     // load the result and close the frame
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_sync;
      logic is_last;
      logic pair_pending;
   } sts_type;

   function automatic logic [RECIP_W-1:0] recip(input logic [PROT_W-1:0] sel);
      logic [RECIP_W-1:0] r;
      case (sel)
         PROTO_ONE:   r = 17'd33825;   // 2^20 / 31
         PROTO_TWO:   r = 17'd104857;  // 2^20 / 10
         PROTO_THREE: r = 17'd14768;   // 2^20 / 71
         default:     r = 17'd10485;   // 2^20 / 100
      endcase
      return r;
   endfunction

   function automatic logic [DIVR_W-1:0] divisor(input logic [PROT_W-1:0] sel);
      logic [DIVR_W-1:0] d;
      case (sel)
         PROTO_ONE:   d = 7'd31;
         PROTO_TWO:   d = 7'd10;
         PROTO_THREE: d = 7'd71;
         default:     d = 7'd100;
      endcase
      return d;
   endfunction

   // Pulse lengths in units, for the 0 pattern and the 1 pattern
   function automatic logic [MULT_W-1:0] zero_hi(input logic [PROT_W-1:0] p);
      logic [MULT_W-1:0] m;
      case (p)
         PROTO_TWO:   m = 4'd1;
         PROTO_THREE: m = 4'd4;
         default:     m = 4'd1;
      endcase
      return m;
   endfunction

   function automatic logic [MULT_W-1:0] zero_lo(input logic [PROT_W-1:0] p);
      logic [MULT_W-1:0] m;
      case (p)
         PROTO_TWO:   m = 4'd2;
         PROTO_THREE: m = 4'd11;
         default:     m = 4'd3;
      endcase
      return m;
   endfunction

   function automatic logic [MULT_W-1:0] one_hi(input logic [PROT_W-1:0] p);
      logic [MULT_W-1:0] m;
      case (p)
         PROTO_TWO:   m = 4'd2;
         PROTO_THREE: m = 4'd9;
         default:     m = 4'd3;
      endcase
      return m;
   endfunction

   function automatic logic [MULT_W-1:0] one_lo(input logic [PROT_W-1:0] p);
      logic [MULT_W-1:0] m;
      case (p)
         PROTO_TWO:   m = 4'd1;
         PROTO_THREE: m = 4'd6;
         default:     m = 4'd1;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

### sv/ookpwd_if.sv
//------------------------------------------------------------------------------
// ookpwd_if
// Valid/ready channels for pulse durations in and decoded frames out.
//------------------------------------------------------------------------------
`default_nettype none

interface ookpwd_req_if;
   logic                          valid;
   logic                          ready;
   logic [ookpwd_pkg::DUR_W-1:0]  duration_us;
   logic                          is_sync;
   logic                          is_last;

   modport source (output valid, duration_us, is_sync, is_last, input ready);
   modport sink   (input valid, duration_us, is_sync, is_last, output ready);
endinterface

interface ookpwd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ookpwd_pkg::CODE_W-1:0] received_code;
   logic [ookpwd_pkg::CNT_W-1:0]  bit_count;
   logic [ookpwd_pkg::UNIT_W-1:0] unit_delay;
   logic [ookpwd_pkg::PROT_W-1:0] protocol_used;
   logic                          stored;
   logic                          success;

   modport source (output valid, received_code, bit_count, unit_delay, protocol_used,
                   stored, success, input ready);
   modport sink   (input valid, received_code, bit_count, unit_delay, protocol_used,
                   stored, success, output ready);
endinterface

`default_nettype wire

### sv/ook_pulse_width_decoder.sv
//------------------------------------------------------------------------------
// ook_pulse_width_decoder
// Top level of the OOK remote-control pulse width decoder.
//------------------------------------------------------------------------------
// One duration is taken at a time. A plain duration that opens a high/low
// pair passes through the step state only. One that closes a pair of a
// frame that has not failed also passes through the centre and classify
// states, because the window centres are registered before the compare. A
// closing duration in a failed or overlong frame skips those two states. A
// sync gap runs the shared constant divider (reciprocal multiply, then
// remainder correction) twice: once for the unit delay and once for the
// tolerance window after the unit-times-percent multiply. A last duration
// also holds the block until the result register is free; a result still
// waiting in that register does not stop further durations from being taken.
// Configuration writes take effect at the next item that samples them.
`default_nettype none

module ook_pulse_width_decoder #(
   parameter int CODE_BITS = ookpwd_pkg::CODE_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   ookpwd_req_if.sink                         req_chan,
   ookpwd_rsp_if.source                       rsp_chan,
   input  wire                                csr_we,
   input  wire  [ookpwd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [ookpwd_pkg::CSR_DAT_W-1:0]   csr_data
);

   ookpwd_pkg::cmd_type cmd;
   ookpwd_pkg::sts_type sts;
   logic                req_ready;
   logic                rsp_valid;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   // Sequencer
   ookpwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath
   ookpwd_dp #(
      .CODE_BITS (CODE_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .duration_us   (req_chan.duration_us),
      .is_sync       (req_chan.is_sync),
      .is_last       (req_chan.is_last),
      .cmd           (cmd),
      .sts           (sts),
      .received_code (rsp_chan.received_code),
      .bit_count     (rsp_chan.bit_count),
      .unit_delay    (rsp_chan.unit_delay),
      .protocol_used (rsp_chan.protocol_used),
      .stored        (rsp_chan.stored),
      .success       (rsp_chan.success)
   );

endmodule

`default_nettype wire

### sv/ookpwd_ctrl.sv
//------------------------------------------------------------------------------
// ookpwd_ctrl
// Sequencer: walks one item through the datapath and owns the result valid.
//------------------------------------------------------------------------------
`default_nettype none

module ookpwd_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  ookpwd_pkg::sts_type  sts,
   output ookpwd_pkg::cmd_type  cmd
);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_UNIT_MUL = 10'b00_0000_0010,
      ST_UNIT_FIX = 10'b00_0000_0100,
      ST_TOL_MUL  = 10'b00_0000_1000,
      ST_WIN_MUL  = 10'b00_0001_0000,
      ST_WIN_FIX  = 10'b00_0010_0000,
      ST_STEP     = 10'b00_0100_0000,
      ST_CENTRE   = 10'b00_1000_0000,
      ST_CLASSIFY = 10'b01_0000_0000,
      ST_DONE     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Output register can take a result when empty or drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_STEP;
            end
         end
         ST_STEP: begin
            if (sts.is_sync) begin
               state_in = ST_UNIT_MUL;
            end else begin
               cmd.step = 1'b1;
               state_in = sts.pair_pending ? ST_CENTRE : ST_DONE;
            end
         end
         ST_UNIT_MUL: begin
            cmd.div_mul = 1'b1;
            state_in    = ST_UNIT_FIX;
         end
         ST_UNIT_FIX: begin
            cmd.unit_fix = 1'b1;
            state_in     = ST_TOL_MUL;
         end
         ST_TOL_MUL: begin
            cmd.tol_mul = 1'b1;
            state_in    = ST_WIN_MUL;
         end
         ST_WIN_MUL: begin
            cmd.div_mul = 1'b1;
            cmd.div_win = 1'b1;
            state_in    = ST_WIN_FIX;
         end
         ST_WIN_FIX: begin
            cmd.win_fix = 1'b1;
            state_in    = ST_DONE;
         end
         ST_CENTRE: begin
            cmd.centre = 1'b1;
            state_in   = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.is_last) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### sv/ookpwd_dp.sv
//------------------------------------------------------------------------------
// ookpwd_dp
// Datapath: config registers, unit and window division, pair classifier,
// frame state and the result register.
//------------------------------------------------------------------------------
`default_nettype none

module ookpwd_dp #(
   parameter int CODE_BITS = ookpwd_pkg::CODE_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // config
   input  wire                                  csr_we,
   input  wire  [ookpwd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [ookpwd_pkg::CSR_DAT_W-1:0]     csr_data,
   // item in
   input  wire  [ookpwd_pkg::DUR_W-1:0]         duration_us,
   input  wire                                  is_sync,
   input  wire                                  is_last,
   // control
   input  ookpwd_pkg::cmd_type                  cmd,
   output ookpwd_pkg::sts_type                  sts,
   // result
   output logic [ookpwd_pkg::CODE_W-1:0]        received_code,
   output logic [ookpwd_pkg::CNT_W-1:0]         bit_count,
   output logic [ookpwd_pkg::UNIT_W-1:0]        unit_delay,
   output logic [ookpwd_pkg::PROT_W-1:0]        protocol_used,
   output logic                                 stored,
   output logic                                 success
);

   localparam int DUR_W   = ookpwd_pkg::DUR_W;
   localparam int UNIT_W  = ookpwd_pkg::UNIT_W;
   localparam int WIN_W   = ookpwd_pkg::WIN_W;
   localparam int CNT_W   = ookpwd_pkg::CNT_W;
   localparam int PROT_W  = ookpwd_pkg::PROT_W;
   localparam int TOL_W   = ookpwd_pkg::TOL_W;
   localparam int CODE_W  = ookpwd_pkg::CODE_W;
   localparam int NUM_W   = ookpwd_pkg::NUM_W;
   localparam int RECIP_W = ookpwd_pkg::RECIP_W;
   localparam int DIVR_W  = ookpwd_pkg::DIVR_W;
   localparam int PROD_W  = ookpwd_pkg::PROD_W;
   localparam int QC_W    = ookpwd_pkg::QC_W;
   localparam int CTR_W   = ookpwd_pkg::CTR_W;
   localparam int CMP_W   = CTR_W + 1;

   // Strict window test: c - w < v < c + w, done without signs
   function automatic logic in_window(input logic [DUR_W-1:0] v,
                                      input logic [CTR_W-1:0] c,
                                      input logic [WIN_W-1:0] w);
      logic [CMP_W-1:0] vw;
      logic [CMP_W-1:0] cw;
      vw = CMP_W'(v) + CMP_W'(w);
      cw = CMP_W'(c) + CMP_W'(w);
      return (vw > CMP_W'(c)) && (CMP_W'(v) < cw);
   endfunction

   // Config registers
   logic [PROT_W-1:0] protocol_ff;
   logic [TOL_W-1:0]  tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_ff <= ookpwd_pkg::PROTO_ONE;
         tol_ff      <= ookpwd_pkg::TOL_RESET;
      end else if (csr_we) begin
         if (csr_index == ookpwd_pkg::CSR_PROTOCOL) begin
            protocol_ff <= csr_data[PROT_W-1:0];
         end else begin
            tol_ff <= csr_data;
         end
      end
   end

   // Captured item, protocol folded to a valid one
   logic [DUR_W-1:0]  dur_ff;
   logic              sync_ff;
   logic              last_ff;
   logic [PROT_W-1:0] prot_ff;
   logic [PROT_W-1:0] prot_eff;

   assign prot_eff = (protocol_ff == ookpwd_pkg::PROTO_RSVD) ? ookpwd_pkg::PROTO_ONE
                                                             : protocol_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dur_ff  <= duration_us;
         sync_ff <= is_sync;
         last_ff <= is_last;
         prot_ff <= prot_eff;
      end
   end

   // Constant divider, first step: reciprocal multiply
   logic [NUM_W-1:0]  div_num_ff;
   logic [PROT_W-1:0] div_sel_ff;
   logic [PROD_W-1:0] div_prod_ff;
   logic [NUM_W-1:0]  div_num_in;
   logic [PROT_W-1:0] div_sel_in;
   logic [NUM_W-1:0]  tolprod_ff;

   assign div_num_in = cmd.div_win ? tolprod_ff : NUM_W'(dur_ff);
   assign div_sel_in = cmd.div_win ? ookpwd_pkg::DIV_PERCENT : prot_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_mul) begin
         div_num_ff  <= div_num_in;
         div_sel_ff  <= div_sel_in;
         div_prod_ff <= PROD_W'(div_num_in) * PROD_W'(ookpwd_pkg::recip(div_sel_in));
      end
   end

   // Second step: estimate is exact or one short, fix by the remainder
   logic [RECIP_W-1:0] quot_est;
   logic [DIVR_W-1:0]  div_dv;
   logic [QC_W-1:0]    quot_rem;
   logic [RECIP_W-1:0] quot;

   assign quot_est = div_prod_ff[ookpwd_pkg::DIV_SHIFT +: RECIP_W];
   assign div_dv   = ookpwd_pkg::divisor(div_sel_ff);
   assign quot_rem = QC_W'(div_num_ff) - QC_W'(quot_est) * QC_W'(div_dv);
   assign quot     = (quot_rem >= QC_W'(div_dv)) ? quot_est + RECIP_W'(1) : quot_est;

   // Frame state
   logic [UNIT_W-1:0]    unit_ff, unit_in;
   logic [WIN_W-1:0]     window_ff, window_in;
   logic [CODE_BITS-1:0] code_ff, code_in;
   logic                 failed_ff, failed_in;
   logic [DUR_W-1:0]     held_ff, held_in;
   logic                 phase_ff, phase_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [NUM_W-1:0]     tolprod_in;
   logic                 overflow;

   // Window centres for the held high and the current low
   logic [CTR_W-1:0] c_zh_ff, c_zl_ff, c_oh_ff, c_ol_ff;

   always_ff @(posedge clock) begin
      if (cmd.centre) begin
         c_zh_ff <= CTR_W'(ookpwd_pkg::zero_hi(prot_ff)) * CTR_W'(unit_ff);
         c_zl_ff <= CTR_W'(ookpwd_pkg::zero_lo(prot_ff)) * CTR_W'(unit_ff);
         c_oh_ff <= CTR_W'(ookpwd_pkg::one_hi(prot_ff)) * CTR_W'(unit_ff);
         c_ol_ff <= CTR_W'(ookpwd_pkg::one_lo(prot_ff)) * CTR_W'(unit_ff);
      end
   end

   logic zero_ok, one_ok;
   assign zero_ok = in_window(held_ff, c_zh_ff, window_ff) &&
                    in_window(dur_ff, c_zl_ff, window_ff);
   assign one_ok  = in_window(held_ff, c_oh_ff, window_ff) &&
                    in_window(dur_ff, c_ol_ff, window_ff);

   assign overflow   = (count_ff >= ookpwd_pkg::MAX_CHANGES);
   assign tolprod_in = NUM_W'(unit_ff) * NUM_W'(tol_ff);

   // Status: a second pulse of a pair that still needs comparing
   assign sts.is_sync      = sync_ff;
   assign sts.is_last      = last_ff;
   assign sts.pair_pending = phase_ff && !failed_ff && !overflow;

   // Frame state updates
   always_comb begin
      unit_in   = unit_ff;
      window_in = window_ff;
      code_in   = code_ff;
      failed_in = failed_ff;
      held_in   = held_ff;
      phase_in  = phase_ff;
      count_in  = count_ff;

      if (cmd.unit_fix) begin
         unit_in   = quot[UNIT_W-1:0];
         code_in   = '0;
         failed_in = 1'b0;
         held_in   = '0;
         phase_in  = 1'b0;
         count_in  = CNT_W'(1);
      end

      if (cmd.win_fix) begin
         window_in = quot[WIN_W-1:0];
      end

      if (cmd.step) begin
         if (overflow) begin
            count_in  = ookpwd_pkg::MAX_CHANGES;
            failed_in = 1'b1;
            code_in   = '0;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
         if (!phase_ff) begin
            held_in  = dur_ff;
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
         end
      end

      // Zero pattern has priority over one pattern
      if (cmd.classify) begin
         if (zero_ok) begin
            code_in = {code_ff[CODE_BITS-2:0], 1'b0};
         end else if (one_ok) begin
            code_in = {code_ff[CODE_BITS-2:0], 1'b1};
         end else begin
            failed_in = 1'b1;
            code_in   = '0;
         end
      end

      // Close the frame after the last duration
      if (cmd.finish) begin
         failed_in = 1'b1;
         code_in   = '0;
         held_in   = '0;
         phase_in  = 1'b0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff   <= '0;
         window_ff <= '0;
         code_ff   <= '0;
         failed_ff <= 1'b0;
         held_ff   <= '0;
         phase_ff  <= 1'b0;
         count_ff  <= '0;
      end else begin
         unit_ff   <= unit_in;
         window_ff <= window_in;
         code_ff   <= code_in;
         failed_ff <= failed_in;
         held_ff   <= held_in;
         phase_ff  <= phase_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tol_mul) begin
         tolprod_ff <= tolprod_in;
      end
   end

   // Result: an unpaired final pulse fails the frame
   logic [CODE_BITS+CODE_W-1:0] code_ext;
   logic [CODE_W-1:0]           code_out;

   assign code_ext = {{CODE_W{1'b0}}, code_ff};
   assign code_out = (failed_ff || phase_ff) ? '0 : code_ext[CODE_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         received_code <= code_out;
         bit_count     <= count_ff >> 1;
         unit_delay    <= unit_ff;
         protocol_used <= prot_ff;
         stored        <= (count_ff > ookpwd_pkg::STORED_MIN);
         success       <= (code_out != '0);
      end
   end

endmodule

`default_nettype wire

### sv/ookpwd_checker.sv
//------------------------------------------------------------------------------
// ookpwd_checker
// Port-level assertions for the decoder, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module ookpwd_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_ready,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire [ookpwd_pkg::CODE_W-1:0]       received_code,
   input wire [ookpwd_pkg::CNT_W-1:0]        bit_count,
   input wire [ookpwd_pkg::PROT_W-1:0]       protocol_used,
   input wire                                success
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its code
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(received_code))
      else $error("result code changed while stalled");

   // Success flag agrees with the code
   a_success: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (success == (received_code != '0)))
      else $error("success flag disagrees with code");

   // A nonzero code needs at least one pair; protocol is never the spare code
   a_code_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((received_code == '0) || (bit_count != '0)) &&
                    (protocol_used != ookpwd_pkg::PROTO_RSVD))
      else $error("result fields inconsistent");

   // One item at a time: ready drops after an item is taken
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while busy");

endmodule

bind ook_pulse_width_decoder ookpwd_checker u_ookpwd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .received_code (rsp_chan.received_code),
   .bit_count     (rsp_chan.bit_count),
   .protocol_used (rsp_chan.protocol_used),
   .success       (rsp_chan.success)
);

`default_nettype wire
